@@ hdl/des_pkg.sv @@
// Shared widths, opcodes and status codes of the deduplicating event stack.
package des_pkg;

  // Fixed payload widths
  localparam int unsigned OpW     = 1;
  localparam int unsigned IdW     = 8;
  localparam int unsigned StatusW = 2;

  // Operation codes
  localparam logic [OpW-1:0] OP_POST = 1'b0;
  localparam logic [OpW-1:0] OP_POP  = 1'b1;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_OVER    = 2'd3
  } status_e;

endpackage

@@ hdl/des_if.sv @@
// Valid/ready channel interfaces for the request and response items.
interface des_req_if;
  logic                       valid;
  logic                       ready;
  logic [des_pkg::OpW-1:0]    op;
  logic [des_pkg::IdW-1:0]    event_id;

  modport source (output valid, output op, output event_id, input ready);
  modport sink   (input valid, input op, input event_id, output ready);
endinterface

interface des_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [des_pkg::StatusW-1:0]  status;
  logic [des_pkg::IdW-1:0]      event_out;

  modport source (output valid, output status, output event_out, input ready);
  modport sink   (input valid, input status, input event_out, output ready);
endinterface

@@ hdl/dedup_event_stack_unit.sv @@
// Top level: deduplicating LIFO event store with a sequential duplicate scan.
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    op (0 post, 1 pop), event_id[7:0]
//  rsp_o    out  valid/ready    status[1:0], event_out[7:0]
//
// A post scans the stored codes one per cycle through the slot RAM's single
// read port and one comparator. One item at a time is worked.
// Reset (rst_ni, async low) empties the store; slot contents are not cleared.
// The result sits in an output register; the next item is taken while it
// waits, but finishing that next item stalls until the result is taken.
module dedup_event_stack_unit #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned EVENT_WIDTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  des_req_if.sink   req_i,
  des_rsp_if.source rsp_o
);

  import des_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned WideW = (EVENT_WIDTH > IdW) ? EVENT_WIDTH : IdW;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_POPRD = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [EVENT_WIDTH-1:0] code_q, code_d;
  status_e                res_status_q, res_status_d;
  logic [IdW-1:0]         res_event_q, res_event_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q;
  logic [IdW-1:0]         out_event_q;

  logic                   accept;
  logic                   out_free;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [EVENT_WIDTH-1:0] ram_rdata;
  logic [WideW-1:0]       id_wide;
  logic [WideW-1:0]       rd_wide;
  logic [EVENT_WIDTH-1:0] id_code;
  logic [CW-1:0]          count_dec;
  logic [CW-1:0]          idx_next;

  // Width adaption between the 8-bit ports and the stored code width
  assign id_wide = WideW'(req_i.event_id);
  assign id_code = id_wide[EVENT_WIDTH-1:0];
  assign rd_wide = WideW'(ram_rdata);

  assign count_dec = count_q - CW'(1);
  assign idx_next  = CW'(idx_q) + CW'(1);

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign ram_waddr   = count_q[AW-1:0];

  // Slot storage
  des_ram #(
    .WIDTH (EVENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (code_d),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: scan, pop read, result hand-off
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    code_d       = code_q;
    res_status_d = res_status_q;
    res_event_d  = res_event_q;
    ram_we       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          code_d      = id_code;
          res_event_d = '0;
          idx_d       = '0;
          if (req_i.op == OP_POST) begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = ST_OVER;
              state_d      = S_FIN;
            end else if (count_q == '0) begin
              ram_we       = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = ST_OK;
              state_d      = S_FIN;
            end else begin
              ram_raddr = '0;
              state_d   = S_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_FIN;
            end else begin
              ram_raddr = count_dec[AW-1:0];
              state_d   = S_POPRD;
            end
          end
        end
      end
      S_SCAN: begin
        ram_raddr = idx_next[AW-1:0];
        if (ram_rdata == code_q) begin
          res_status_d = ST_PRESENT;
          state_d      = S_FIN;
        end else if (idx_next == count_q) begin
          // no match among stored codes: append
          ram_we       = 1'b1;
          count_d      = count_q + CW'(1);
          res_status_d = ST_OK;
          state_d      = S_FIN;
        end else begin
          idx_d = idx_next[AW-1:0];
        end
      end
      S_POPRD: begin
        res_status_d = ST_OK;
        res_event_d  = rd_wide[IdW-1:0];
        count_d      = count_dec;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_FIN && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    code_q       <= code_d;
    res_status_q <= res_status_d;
    res_event_q  <= res_event_d;
    if (state_q == S_FIN && out_free) begin
      out_status_q <= res_status_q;
      out_event_q  <= res_event_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.event_out = out_event_q;

endmodule

@@ hdl/des_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module des_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
